[hw/rtl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int CMD_W   = 2;
    localparam int PAGE_W  = 12;
    localparam int COUNT_W = 13;
    localparam int DATA_W  = 32;

    localparam logic [COUNT_W-1:0] MANAGED_RESET = 13'd4096;

    // Register select: bit 2 of the byte address picks the 32-bit word.
    localparam logic [0:0] REG_PAGES_MANAGED = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

endpackage

[hw/rtl/pba_ram.sv]
// ----------------------------------------------------------------------------
// pba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Next-fit page allocator over a one-bit-per-page used map held in a RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         command, first_page, page_count
//  m_*       out        status, run_base_page, run_pages
//  APB       in/out     pages_managed at byte address 0
//
// The used map is walked one page per cycle through the RAM's read port.
// Free and mark-used write their range into the map; an allocate scans for
// a free run, marks it used, and then gives its result beat.
// After reset the map is filled with ones while s_tready is low.
// A new command is taken while an earlier result still waits on m_*.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
    parameter int PAGES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // [1:0] command, [13:2] first_page, [26:14] page_count, rest zero
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] status, [12:1] run_base_page, [25:13] run_pages, rest zero
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(PAGES);
    localparam int W  = (AW + 1 > 14) ? AW + 1 : 14;
    localparam logic [W-1:0] PAGES_W = W'(PAGES);
    localparam logic [W-1:0] LAST_W  = W'(PAGES - 1);
    localparam int CW = pba_pkg::COUNT_W;
    localparam int PW = pba_pkg::PAGE_W;

    pba_pkg::state_t state_reg, state_next;

    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  end_reg, end_next;
    logic          wr_bit_reg, wr_bit_next;
    logic [CW-1:0] count_reg, count_next;
    logic [W-1:0]  scan_i_reg, scan_i_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] chk_reg, chk_next;
    logic [CW-1:0] run_reg, run_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] search_start_reg, search_start_next;
    logic          res_status_reg, res_status_next;
    logic [PW-1:0] res_base_reg, res_base_next;
    logic [CW-1:0] res_pages_reg, res_pages_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;
    logic [CW-1:0] pages_managed_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;
    logic          out_load;

    pba_pkg::cmd_t in_cmd;
    logic [PW-1:0] in_first;
    logic [CW-1:0] in_count;
    logic [W-1:0]  limit;
    logic [W-1:0]  pm_w;
    logic [CW-1:0] run_inc;
    logic [AW-1:0] found_base;
    logic [W-1:0]  found_base_w;
    logic [W-1:0]  found_end;
    logic          cfg_write;

    assign in_cmd   = pba_pkg::cmd_t'(s_tdata[1:0]);
    assign in_first = s_tdata[13:2];
    assign in_count = s_tdata[26:14];

    assign pm_w  = W'(pages_managed_reg);
    assign limit = (pm_w < PAGES_W) ? pm_w : PAGES_W;

    assign run_inc      = run_reg + CW'(1);
    assign found_base   = (run_reg == '0) ? chk_reg : base_reg;
    assign found_base_w = W'(found_base);
    assign found_end    = found_base_w + W'(count_reg);

    pba_ram #(
        .WIDTH (1),
        .DEPTH (PAGES)
    ) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready
                       & (paddr[2] == pba_pkg::REG_PAGES_MANAGED);

    always_comb begin
        prdata = '0;
        if (paddr[2] == pba_pkg::REG_PAGES_MANAGED) begin
            prdata = 32'(pages_managed_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_managed_reg <= pba_pkg::MANAGED_RESET;
        end else if (cfg_write) begin
            pages_managed_reg <= pwdata[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= pba_pkg::ST_CLEAR;
            p_reg            <= '0;
            pend_reg         <= 1'b0;
            search_start_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            p_reg            <= p_next;
            pend_reg         <= pend_next;
            search_start_reg <= search_start_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg        <= end_next;
        wr_bit_reg     <= wr_bit_next;
        count_reg      <= count_next;
        scan_i_reg     <= scan_i_next;
        chk_reg        <= chk_next;
        run_reg        <= run_next;
        base_reg       <= base_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        res_pages_reg  <= res_pages_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb begin
        state_next        = state_reg;
        p_next            = p_reg;
        end_next          = end_reg;
        wr_bit_next       = wr_bit_reg;
        count_next        = count_reg;
        scan_i_next       = scan_i_reg;
        pend_next         = pend_reg;
        chk_next          = chk_reg;
        run_next          = run_reg;
        base_next         = base_reg;
        search_start_next = search_start_reg;
        res_status_next   = res_status_reg;
        res_base_next     = res_base_reg;
        res_pages_next    = res_pages_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        mem_we            = 1'b0;
        mem_waddr         = p_reg[AW-1:0];
        mem_wdata         = wr_bit_reg;
        mem_raddr         = scan_i_reg[AW-1:0];
        s_tready          = 1'b0;
        out_load          = 1'b0;

        unique case (state_reg)
            pba_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                p_next    = p_reg + W'(1);
                if (p_reg == LAST_W) begin
                    state_next = pba_pkg::ST_IDLE;
                end
            end

            pba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    count_next      = in_count;
                    res_status_next = 1'b0;
                    res_base_next   = '0;
                    res_pages_next  = '0;
                    unique case (in_cmd)
                        pba_pkg::CMD_ALLOC: begin
                            if (in_count == '0) begin
                                // An empty request succeeds and rewinds the search.
                                search_start_next = '0;
                                state_next        = pba_pkg::ST_RESP;
                            end else begin
                                scan_i_next = W'(search_start_reg);
                                run_next    = '0;
                                pend_next   = 1'b0;
                                state_next  = pba_pkg::ST_SCAN;
                            end
                        end
                        pba_pkg::CMD_FREE, pba_pkg::CMD_MARK: begin
                            p_next      = W'(in_first);
                            end_next    = W'(in_first) + W'(in_count);
                            wr_bit_next = (in_cmd == pba_pkg::CMD_MARK);
                            state_next  = pba_pkg::ST_WRITE;
                        end
                        pba_pkg::CMD_NONE: begin
                            state_next = pba_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            pba_pkg::ST_SCAN: begin
                // Reads are issued one page ahead; the bit of chk_reg arrives now.
                if (scan_i_reg < limit) begin
                    pend_next   = 1'b1;
                    chk_next    = scan_i_reg[AW-1:0];
                    scan_i_next = scan_i_reg + W'(1);
                end else begin
                    pend_next = 1'b0;
                end

                if (pend_reg) begin
                    if (!mem_rdata) begin
                        if (run_reg == '0) begin
                            base_next = chk_reg;
                        end
                        run_next = run_inc;
                        if (run_inc == count_reg) begin
                            p_next         = found_base_w;
                            end_next       = found_end;
                            wr_bit_next    = 1'b1;
                            res_base_next  = found_base_w[PW-1:0];
                            res_pages_next = count_reg;
                            if (found_end >= PAGES_W) begin
                                search_start_next = '0;
                            end else begin
                                search_start_next = found_end[AW-1:0];
                            end
                            state_next = pba_pkg::ST_WRITE;
                        end
                    end else begin
                        run_next = '0;
                    end
                end else if (scan_i_reg >= limit) begin
                    if (search_start_reg != '0) begin
                        // First pass failed: retry once from page zero.
                        search_start_next = '0;
                        scan_i_next       = '0;
                        run_next          = '0;
                        pend_next         = 1'b0;
                    end else begin
                        res_status_next = 1'b1;
                        state_next      = pba_pkg::ST_RESP;
                    end
                end
            end

            pba_pkg::ST_WRITE: begin
                if ((p_reg < end_reg) && (p_reg < PAGES_W)) begin
                    mem_we = 1'b1;
                    p_next = p_reg + W'(1);
                end else begin
                    state_next = pba_pkg::ST_RESP;
                end
            end

            pba_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = pba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pba_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, res_pages_reg, res_base_reg, res_status_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The map is only read while a scan runs, never written.
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pba_pkg::ST_SCAN) |-> !mem_we)
        else $error("used map written during a scan");

    // A scan always leaves as soon as the run reaches the requested length.
    a_run_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pba_pkg::ST_SCAN) |-> (run_reg < count_reg))
        else $error("run length reached request without ending the scan");

    // A failed allocation reports neither a base nor a page count.
    a_fail_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[25:1] == '0))
        else $error("failure result carries nonzero base or pages");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit page bitmap allocator. A predictor
// keeps its own copy of the used map, the search start and the managed page
// count, and computes the result of every accepted command. Each result beat
// is checked field by field against the oldest prediction. A directed part
// covers the special cases and a long receiver hold-off. Random phases under
// several managed counts follow, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAP_PAGES   = 4096;
    localparam int MAX_GAP     = 17;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PAGE_W      = pba_pkg::PAGE_W;
    localparam int COUNT_W     = pba_pkg::COUNT_W;
    localparam logic [2:0] PAGES_MANAGED_ADDR = {pba_pkg::REG_PAGES_MANAGED, 2'b00};
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_RUN = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] pages;
        logic [PAGE_W-1:0]  base;
        logic               status;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    bit                 page_used [MAP_PAGES];
    logic [PAGE_W-1:0]  search_from;
    logic [COUNT_W-1:0] managed_pages;

    alloc_result_t pending_results[$];
    int  mismatch_count;
    bit  src_idle;
    bit  sink_idle;
    bit  hold_request;

    page_bitmap_allocator #(.PAGES(MAP_PAGES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #100_000_000;
        $display("page_bitmap_allocator: mismatch");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit find_free_run(int start, int count, int limit, output int base);
        int run;
        int b;
        run = 0;
        b = 0;
        for (int i = start; i < limit && run < count; i++) begin
            if (!page_used[i]) begin
                if (run == 0) b = i;
                run++;
            end else begin
                run = 0;
            end
        end
        base = b;
        return run >= count;
    endfunction

    function automatic void set_range(int first, int count, bit used);
        for (int i = 0; i < count; i++) begin
            if (first + i < MAP_PAGES) page_used[first + i] = used;
        end
    endfunction

    function automatic alloc_result_t apply_command(pba_pkg::cmd_t cmd,
                                                    logic [PAGE_W-1:0] first,
                                                    logic [COUNT_W-1:0] count);
        alloc_result_t res;
        int limit;
        int base;
        bit found;
        res = '0;
        limit = (int'(managed_pages) < MAP_PAGES) ? int'(managed_pages) : MAP_PAGES;
        case (cmd)
            pba_pkg::CMD_ALLOC: begin
                found = find_free_run(int'(search_from), int'(count), limit, base);
                // A failed scan that did not start at page zero gets one retry from zero.
                if (!found && search_from != '0) begin
                    search_from = '0;
                    found = find_free_run(0, int'(count), limit, base);
                end
                if (!found) begin
                    res.status = STATUS_NO_RUN;
                end else begin
                    if (count == '0) base = 0;
                    set_range(base, int'(count), 1'b1);
                    search_from = (base + int'(count) >= MAP_PAGES) ? '0
                                  : PAGE_W'(base + int'(count));
                    res.status = STATUS_OK;
                    res.base   = PAGE_W'(base);
                    res.pages  = count;
                end
            end
            pba_pkg::CMD_FREE: set_range(int'(first), int'(count), 1'b0);
            pba_pkg::CMD_MARK: set_range(int'(first), int'(count), 1'b1);
            default: ;
        endcase
        return res;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_command(pba_pkg::cmd_t cmd, logic [PAGE_W-1:0] first,
                                logic [COUNT_W-1:0] count);
        int gap;
        gap = src_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, count, first, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_command(cmd, first, count));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Only called while no command is in flight.
    task automatic write_managed(logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAGES_MANAGED_ADDR;
        pwdata  <= {19'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        managed_pages = value;
        // Read the register back in a second transfer.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[COUNT_W-1:0] != value)
            report_mismatch("pages_managed readback", int'(prdata[COUNT_W-1:0]), int'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result receiver with random stalls and an occasional long hold-off.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = sink_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[25:0];
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.base != want.base)
                    report_mismatch("run_base_page", int'(got.base), int'(want.base));
                if (got.pages != want.pages)
                    report_mismatch("run_pages", int'(got.pages), int'(want.pages));
            end
        end
    end

    // After reset every page is used.
    task automatic test_full_map();
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd1);
        send_command(pba_pkg::CMD_ALLOC, 12'd4095, 13'd0);
        send_command(pba_pkg::CMD_NONE, 12'd4095, 13'd4096);
    endtask

    task automatic test_range_extremes();
        send_command(pba_pkg::CMD_FREE, 12'd0, 13'd4096);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd4096);
        // Only the last page lies inside the store.
        send_command(pba_pkg::CMD_FREE, 12'd4095, 13'd4096);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd1);
        send_command(pba_pkg::CMD_MARK, 12'd0, 13'd0);
        send_command(pba_pkg::CMD_FREE, 12'd100, 13'd0);
    endtask

    task automatic test_next_fit();
        send_command(pba_pkg::CMD_FREE, 12'd0, 13'd16);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd8);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd8);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd4);
    endtask

    task automatic test_managed_count();
        wait_idle();
        write_managed(13'd0);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd1);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd0);
        wait_idle();
        write_managed(13'd8191);
        send_command(pba_pkg::CMD_FREE, 12'd4090, 13'd6);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd6);
        wait_idle();
        write_managed(13'd4096);
        send_command(pba_pkg::CMD_FREE, 12'd200, 13'd10);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd5);
        wait_idle();
        // The search start now lies beyond the managed count.
        write_managed(13'd100);
        send_command(pba_pkg::CMD_FREE, 12'd10, 13'd10);
        send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'd3);
        wait_idle();
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        write_managed(13'd64);
        send_command(pba_pkg::CMD_FREE, 12'd0, 13'd64);
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++) begin
            if (i % 3 == 2) send_command(pba_pkg::CMD_FREE, 12'(i * 4), 13'd3);
            else            send_command(pba_pkg::CMD_ALLOC, 12'd0, 13'(1 + i % 4));
        end
        wait_idle();
    endtask

    task automatic test_random();
        int managed_set [6] = '{1, 0, 64, 300, 4096, 8191};
        int beats_set [6]   = '{8, 22, 28, 28, 8, 8};
        int value;
        int lim;
        int r;
        pba_pkg::cmd_t cmd;
        logic [PAGE_W-1:0]  first;
        logic [COUNT_W-1:0] count;
        for (int ph = 0; ph < 6; ph++) begin
            value = (managed_set[ph] == 0) ? int'($urandom_range(8, 40)) : managed_set[ph];
            lim   = (value > MAP_PAGES) ? MAP_PAGES : value;
            src_idle  = (ph % 3 != 2);
            sink_idle = (ph % 2 == 0);
            wait_idle();
            write_managed(COUNT_W'(value));
            send_command(pba_pkg::CMD_FREE, 12'd0, COUNT_W'(lim));
            for (int n = 0; n < beats_set[ph]; n++) begin
                r = int'($urandom_range(0, 99));
                if (r < 45)      cmd = pba_pkg::CMD_ALLOC;
                else if (r < 75) cmd = pba_pkg::CMD_FREE;
                else if (r < 92) cmd = pba_pkg::CMD_MARK;
                else             cmd = pba_pkg::CMD_NONE;
                if ($urandom_range(0, 9) == 0)
                    first = PAGE_W'($urandom_range(0, MAP_PAGES - 1));
                else
                    first = PAGE_W'($urandom_range(0, lim - 1));
                if (cmd == pba_pkg::CMD_ALLOC) begin
                    if ($urandom_range(0, 19) == 0)
                        count = COUNT_W'($urandom_range(0, MAP_PAGES));
                    else
                        count = COUNT_W'($urandom_range(0, lim / 4 + 1));
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        count = COUNT_W'($urandom_range(0, MAP_PAGES));
                    else
                        count = COUNT_W'($urandom_range(0, lim / 2 + 1));
                end
                send_command(cmd, first, count);
            end
        end
        wait_idle();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        mismatch_count = 0;
        hold_request   = 1'b0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        for (int i = 0; i < MAP_PAGES; i++) page_used[i] = 1'b1;
        search_from   = '0;
        managed_pages = pba_pkg::MANAGED_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // The map is filled during the clearing pass; wait for the input to open.
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        test_full_map();
        test_range_extremes();
        test_next_fit();
        test_managed_count();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("page_bitmap_allocator: match");
        end else begin
            $display("page_bitmap_allocator: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/pba_pkg.sv
hw/rtl/pba_ram.sv
hw/rtl/page_bitmap_allocator.sv
verif/tb_top.sv
